// ===== rtl/scle_pkg.sv =====
// Shared types, codes and the key map of the scan code line editor.
// No dependencies; the top, front, queue, back and bench files import it.
package scle_pkg;

   // Scan codes (set 1)
   localparam logic [7:0] SC_NUM_MAKE    = 8'h56;
   localparam logic [7:0] SC_LSHIFT      = 8'h2A;
   localparam logic [7:0] SC_RSHIFT      = 8'h36;
   localparam logic [7:0] SC_ALT         = 8'h38;
   localparam logic [7:0] SC_CAPS        = 8'h3A;
   localparam logic [7:0] SC_CTRL        = 8'h1D;
   localparam logic [7:0] SC_KEY_D       = 8'h20;
   localparam logic [7:0] SC_LSHIFT_BRK  = 8'hAA;
   localparam logic [7:0] SC_RSHIFT_BRK  = 8'hB6;
   localparam logic [7:0] SC_ALT_BRK     = 8'hB8;
   localparam logic [7:0] SC_CTRL_BRK    = 8'h9D;

   // Character codes with a meaning of their own
   localparam logic [7:0] CH_BS  = 8'h08;
   localparam logic [7:0] CH_NL  = 8'h0A;
   localparam logic [7:0] CH_EOF = 8'hFF;

   // Columns of the key map
   localparam logic [1:0] COL_BASE  = 2'd0;
   localparam logic [1:0] COL_SHIFT = 2'd1;
   localparam logic [1:0] COL_ALT   = 2'd2;

   // Commands from the front to the back
   localparam logic [1:0] OP_CHAR = 2'd0;
   localparam logic [1:0] OP_BS   = 2'd1;
   localparam logic [1:0] OP_NL   = 2'd2;
   localparam logic [1:0] OP_EOF  = 2'd3;

   localparam int QUEUE_DEPTH = 4;
   localparam int QPW         = $clog2(QUEUE_DEPTH);

   typedef struct packed {
      logic [1:0] op;
      logic [7:0] ch;
   } cmd_type;

   // Latin-American layout: {base, shifted, alt}
   function automatic logic [7:0] key_map(input logic [6:0] code, input logic [1:0] col);
      logic [23:0] row;
      logic [7:0]  res;
      row = '0;
      unique case (code)
         7'h02: row = 24'h31_21_7C;
         7'h03: row = 24'h32_22_40;
         7'h04: row = 24'h33_23_00;
         7'h05: row = 24'h34_24_00;
         7'h06: row = 24'h35_25_00;
         7'h07: row = 24'h36_26_00;
         7'h08: row = 24'h37_2F_7B;
         7'h09: row = 24'h38_28_5B;
         7'h0A: row = 24'h39_29_5D;
         7'h0B: row = 24'h30_3D_7D;
         7'h0C: row = 24'h27_3F_5C;
         7'h0E: row = 24'h08_08_00;
         7'h0F: row = 24'h09_09_00;
         7'h10: row = 24'h71_51_40;
         7'h11: row = 24'h77_57_00;
         7'h12: row = 24'h65_45_00;
         7'h13: row = 24'h72_52_00;
         7'h14: row = 24'h74_54_00;
         7'h15: row = 24'h79_59_00;
         7'h16: row = 24'h75_55_00;
         7'h17: row = 24'h69_49_00;
         7'h18: row = 24'h6F_4F_00;
         7'h19: row = 24'h70_50_00;
         7'h1B: row = 24'h2B_2A_00;
         7'h1C: row = 24'h0A_0A_00;
         7'h1E: row = 24'h61_41_00;
         7'h1F: row = 24'h73_53_00;
         7'h20: row = 24'h64_44_00;
         7'h21: row = 24'h66_46_00;
         7'h22: row = 24'h67_47_00;
         7'h23: row = 24'h68_48_00;
         7'h24: row = 24'h6A_4A_00;
         7'h25: row = 24'h6B_4B_00;
         7'h26: row = 24'h6C_4C_00;
         7'h28: row = 24'h7B_5B_00;
         7'h29: row = 24'h7C_00_00;
         7'h2B: row = 24'h7D_5D_00;
         7'h2C: row = 24'h7A_5A_00;
         7'h2D: row = 24'h78_58_00;
         7'h2E: row = 24'h63_43_00;
         7'h2F: row = 24'h76_56_00;
         7'h30: row = 24'h62_42_00;
         7'h31: row = 24'h6E_4E_00;
         7'h32: row = 24'h6D_4D_00;
         7'h33: row = 24'h2C_3B_00;
         7'h34: row = 24'h2E_3A_00;
         7'h35: row = 24'h2D_5F_00;
         7'h39: row = 24'h20_20_20;
         7'h55: row = 24'h3C_3E_7C;
         default: row = '0;
      endcase
      unique case (col)
         COL_SHIFT: res = row[15:8];
         COL_ALT:   res = row[7:0];
         default:   res = row[23:16];
      endcase
      return res;
   endfunction

endpackage

// ===== rtl/scle_if.sv =====
// Valid/ready channel interfaces for scan code words and result words.
// Depends on nothing.
interface scle_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] scan_code;
   modport source (output valid, output scan_code, input ready);
   modport sink   (input valid, input scan_code, output ready);
endinterface

interface scle_rsp_if;
   logic       valid;
   logic       ready;
   logic       destination;
   logic [7:0] char_code;
   logic       last_of_run;
   modport source (output valid, output destination, output char_code, output last_of_run,
                   input ready);
   modport sink   (input valid, input destination, input char_code, input last_of_run,
                   output ready);
endinterface

// ===== rtl/scan_code_to_ascii_line_editor_top.sv =====
// Top level of the set-1 scan code line editor.
// Depends on scle_pkg, scle_if, scle_front, scle_queue, scle_back and scle_ram.
//
// Usage:
//   req_ch carries one raw set-1 scan code word per handshake (valid and
//   ready both high at a rising clock edge). rsp_ch carries result words:
//   destination 0 is an echo for the display, 1 is a byte of a flushed line;
//   char_code 0xFF marks end of file; last_of_run flags the final word that
//   one scan code causes. Codes that act only on modifiers give no word.
//
//   The front end classifies a scan code in the cycle it is accepted and
//   pushes a command into a four-entry queue; req_ch.ready is low only when
//   that queue is full. The back end pops one command when it is idle and its
//   result register is free. An echo passes through the queue and then the
//   result register. A line flush first stores the terminator, then makes the
//   first read of the line store RAM, then emits one word per cycle while
//   rsp_ch takes them, paced by the RAM's single read port and the result
//   register.
//   Reset (synchronous, active high) clears the modifier state, the queue,
//   the line length and the result register. The line store RAM is not
//   cleared; only entries written since the last flush are ever read.
//   When rsp_ch stalls the result register holds its word, the back end
//   waits, the queue fills and then req_ch.ready drops.
module scan_code_to_ascii_line_editor_top
   import scle_pkg::*;
#(
   parameter int LINE_CAPACITY = 32
) (
   input  logic       clock,
   input  logic       reset,
   scle_req_if.sink   req_ch,
   scle_rsp_if.source rsp_ch
);
   logic    cmd_push, cmd_ready, cmd_valid, cmd_pop;
   cmd_type push_cmd, head_cmd;

   scle_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req       (req_ch),
      .cmd_ready (cmd_ready),
      .cmd_push  (cmd_push),
      .cmd       (push_cmd)
   );

   scle_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (cmd_push),
      .push_cmd (push_cmd),
      .ready    (cmd_ready),
      .pop      (cmd_pop),
      .valid    (cmd_valid),
      .head_cmd (head_cmd)
   );

   scle_back #(.LINE_CAPACITY(LINE_CAPACITY)) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (cmd_valid),
      .cmd       (head_cmd),
      .cmd_pop   (cmd_pop),
      .rsp       (rsp_ch)
   );

   // the front never pushes into a full queue
   a_push_space: assert property (@(posedge clock) disable iff (reset)
      cmd_push |-> cmd_ready)
      else $error("command pushed into full queue");

   // the back never pops an empty queue
   a_pop_valid: assert property (@(posedge clock) disable iff (reset)
      cmd_pop |-> cmd_valid)
      else $error("command popped from empty queue");

   // a newline echo is always followed by the flushed line
   a_nl_echo: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && !rsp_ch.destination && rsp_ch.char_code == CH_NL
      |-> !rsp_ch.last_of_run)
      else $error("newline echo marked last");

   // end of file only closes a flushed line
   a_eof_flush: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && rsp_ch.char_code == CH_EOF
      |-> rsp_ch.destination && rsp_ch.last_of_run)
      else $error("end of file outside a flush tail");
endmodule

// ===== rtl/scle_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module scle_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

// ===== rtl/scle_front.sv =====
// Front end: accepts scan code words, tracks modifiers, maps keys to commands.
// Depends on scle_pkg and scle_req_if.
module scle_front
   import scle_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   scle_req_if.sink      req,
   input  logic          cmd_ready,
   output logic          cmd_push,
   output cmd_type       cmd
);
   logic [1:0] column_ff, column_in;
   logic       ctrl_ff, ctrl_in;
   logic       accept;
   logic [7:0] mapped;

   assign req.ready = cmd_ready;
   assign accept    = req.valid && cmd_ready;
   assign mapped    = key_map(req.scan_code[6:0], column_ff);

   always_comb begin
      column_in = column_ff;
      ctrl_in   = ctrl_ff;
      cmd_push  = 1'b0;
      cmd       = '{op: OP_CHAR, ch: mapped};
      if (accept) begin
         if (req.scan_code < SC_NUM_MAKE) begin
            if (req.scan_code == SC_LSHIFT || req.scan_code == SC_RSHIFT) begin
               column_in = COL_SHIFT;
            end else if (req.scan_code == SC_ALT) begin
               column_in = COL_ALT;
            end else if (req.scan_code == SC_CAPS) begin
               column_in = (column_ff == COL_BASE) ? COL_SHIFT : COL_BASE;
            end else if (req.scan_code == SC_CTRL) begin
               ctrl_in = 1'b1;
            end else if (ctrl_ff) begin
               // only Ctrl-D acts: end the line
               if (req.scan_code == SC_KEY_D) begin
                  cmd_push = 1'b1;
                  cmd      = '{op: OP_EOF, ch: CH_EOF};
               end
            end else begin
               cmd_push = 1'b1;
               unique case (mapped)
                  CH_NL:   cmd.op = OP_NL;
                  CH_BS:   cmd.op = OP_BS;
                  default: cmd.op = OP_CHAR;
               endcase
            end
         end else begin
            case (req.scan_code) inside
               SC_LSHIFT_BRK, SC_RSHIFT_BRK, SC_ALT_BRK: column_in = COL_BASE;
               SC_CTRL_BRK: ctrl_in = 1'b0;
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         column_ff <= COL_BASE;
         ctrl_ff   <= 1'b0;
      end else begin
         column_ff <= column_in;
         ctrl_ff   <= ctrl_in;
      end
   end
endmodule

// ===== rtl/scle_queue.sv =====
// Short command queue between the front and back ends.
// Depends on scle_pkg.
module scle_queue
   import scle_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_cmd,
   output logic    ready,
   input  logic    pop,
   output logic    valid,
   output cmd_type head_cmd
);
   cmd_type        slot_ff [QUEUE_DEPTH];
   logic [QPW-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [QPW:0]   count_ff;
   logic           push_ok, pop_ok;

   assign valid    = count_ff != '0;
   assign ready    = count_ff != (QPW+1)'(QUEUE_DEPTH);
   assign push_ok  = push && ready;
   assign pop_ok   = pop && valid;
   assign head_cmd = slot_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push_ok) begin
         slot_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push_ok) wr_ptr_ff <= wr_ptr_ff + 1'b1;
         if (pop_ok)  rd_ptr_ff <= rd_ptr_ff + 1'b1;
         if (push_ok && !pop_ok) begin
            count_ff <= count_ff + 1'b1;
         end else if (pop_ok && !push_ok) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end
endmodule

// ===== rtl/scle_back.sv =====
// Back end: executes commands on the line store and drives the result register.
// Depends on scle_pkg, scle_rsp_if and scle_ram.
module scle_back
   import scle_pkg::*;
#(
   parameter int LINE_CAPACITY = 32
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       cmd_valid,
   input  cmd_type    cmd,
   output logic       cmd_pop,
   scle_rsp_if.source rsp
);
   localparam int AW = $clog2(LINE_CAPACITY);
   localparam int LW = $clog2(LINE_CAPACITY + 1);
   localparam logic [LW-1:0] LAST_SLOT = LW'(LINE_CAPACITY - 1);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_READ = 2'd1;
   localparam logic [1:0] ST_EMIT = 2'd2;

   logic [1:0]    state_ff, state_in;
   logic [LW-1:0] len_ff, len_in;
   logic [LW-1:0] cnt_ff, cnt_in;
   logic [AW-1:0] idx_ff, idx_in;
   logic          valid_ff, valid_in;
   logic          dest_ff, dest_in;
   logic [7:0]    char_ff, char_in;
   logic          last_ff, last_in;
   logic          out_free, out_load;
   logic [LW-1:0] idx_next;
   logic          wr_en, rd_en;
   logic [AW-1:0] wr_addr, rd_addr;
   logic [7:0]    wr_data, rd_data;

   scle_ram #(.WIDTH(8), .DEPTH(LINE_CAPACITY)) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign out_free = !valid_ff || rsp.ready;
   assign idx_next = LW'(idx_ff) + LW'(1);
   assign wr_addr  = len_ff[AW-1:0];
   assign wr_data  = cmd.ch;

   always_comb begin
      state_in = state_ff;
      len_in   = len_ff;
      cnt_in   = cnt_ff;
      idx_in   = idx_ff;
      out_load = 1'b0;
      dest_in  = dest_ff;
      char_in  = char_ff;
      last_in  = last_ff;
      cmd_pop  = 1'b0;
      wr_en    = 1'b0;
      rd_en    = 1'b0;
      rd_addr  = idx_next[AW-1:0];
      unique case (state_ff)
         ST_IDLE: begin
            if (cmd_valid && out_free) begin
               cmd_pop = 1'b1;
               unique case (cmd.op)
                  OP_CHAR: begin
                     // drop when only the terminator slot is left
                     if (len_ff < LAST_SLOT) begin
                        out_load = 1'b1;
                        dest_in  = 1'b0;
                        char_in  = cmd.ch;
                        last_in  = 1'b1;
                        wr_en    = 1'b1;
                        len_in   = len_ff + 1'b1;
                     end
                  end
                  OP_BS: begin
                     if (len_ff != '0) begin
                        out_load = 1'b1;
                        dest_in  = 1'b0;
                        char_in  = CH_BS;
                        last_in  = 1'b1;
                        len_in   = len_ff - 1'b1;
                     end
                  end
                  default: begin
                     // newline echoes first; both store the terminator and flush
                     if (cmd.op == OP_NL) begin
                        out_load = 1'b1;
                        dest_in  = 1'b0;
                        char_in  = CH_NL;
                        last_in  = 1'b0;
                     end
                     wr_en    = 1'b1;
                     cnt_in   = len_ff + 1'b1;
                     idx_in   = '0;
                     state_in = ST_READ;
                  end
               endcase
            end
         end
         ST_READ: begin
            rd_en    = 1'b1;
            rd_addr  = '0;
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (out_free) begin
               out_load = 1'b1;
               dest_in  = 1'b1;
               char_in  = rd_data;
               last_in  = idx_next == cnt_ff;
               if (idx_next == cnt_ff) begin
                  len_in   = '0;
                  state_in = ST_IDLE;
               end else begin
                  // prefetch the next stored word
                  rd_en  = 1'b1;
                  idx_in = idx_next[AW-1:0];
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
      valid_in = out_load ? 1'b1 : (rsp.ready ? 1'b0 : valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         len_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         len_ff   <= len_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      idx_ff <= idx_in;
      if (out_load) begin
         dest_ff <= dest_in;
         char_ff <= char_in;
         last_ff <= last_in;
      end
   end

   assign rsp.valid       = valid_ff;
   assign rsp.destination = dest_ff;
   assign rsp.char_code   = char_ff;
   assign rsp.last_of_run = last_ff;
endmodule

// ===== bench/scle_line_checker.sv =====
`timescale 1ns / 1ps
// Checker for the scan code line editor: watches both channels, predicts result words.
// Depends on scle_pkg and the channel interfaces in scle_if.
module scle_line_checker
   import scle_pkg::*;
#(
   parameter int LINE_CAPACITY = 32
) (
   input  logic clock,
   input  logic reset,
   scle_req_if  req_ch,
   scle_rsp_if  rsp_ch,
   output int   fail_count,
   output int   words_outstanding
);

   localparam logic DEST_ECHO = 1'b0;
   localparam logic DEST_LINE = 1'b1;

   typedef struct packed {
      logic       destination;
      logic [7:0] char_code;
      logic       last_of_run;
   } out_word_type;

   logic [1:0]   column;
   logic         ctrl_down;
   logic [7:0]   pending_line [LINE_CAPACITY];
   int           line_len;
   out_word_type expected_q [$];
   out_word_type run_q [$];

   // Latin-American layout, packed as {base, shifted, alt}
   function automatic logic [7:0] latin_key_char(input logic [7:0] code, input logic [1:0] col);
      logic [23:0] trio;
      case (code)
         8'h02: trio = "1!|";
         8'h03: trio = {"2", 8'h22, "@"};
         8'h04: trio = {"3#", 8'h00};
         8'h05: trio = {"4$", 8'h00};
         8'h06: trio = {"5%", 8'h00};
         8'h07: trio = {"6&", 8'h00};
         8'h08: trio = "7/{";
         8'h09: trio = "8([";
         8'h0A: trio = "9)]";
         8'h0B: trio = "0=}";
         8'h0C: trio = {"'?", 8'h5C};
         8'h0E: trio = {CH_BS, CH_BS, 8'h00};
         8'h0F: trio = {8'h09, 8'h09, 8'h00};
         8'h10: trio = "qQ@";
         8'h11: trio = {"wW", 8'h00};
         8'h12: trio = {"eE", 8'h00};
         8'h13: trio = {"rR", 8'h00};
         8'h14: trio = {"tT", 8'h00};
         8'h15: trio = {"yY", 8'h00};
         8'h16: trio = {"uU", 8'h00};
         8'h17: trio = {"iI", 8'h00};
         8'h18: trio = {"oO", 8'h00};
         8'h19: trio = {"pP", 8'h00};
         8'h1B: trio = {"+*", 8'h00};
         8'h1C: trio = {CH_NL, CH_NL, 8'h00};
         8'h1E: trio = {"aA", 8'h00};
         8'h1F: trio = {"sS", 8'h00};
         8'h20: trio = {"dD", 8'h00};
         8'h21: trio = {"fF", 8'h00};
         8'h22: trio = {"gG", 8'h00};
         8'h23: trio = {"hH", 8'h00};
         8'h24: trio = {"jJ", 8'h00};
         8'h25: trio = {"kK", 8'h00};
         8'h26: trio = {"lL", 8'h00};
         8'h28: trio = {"{[", 8'h00};
         8'h29: trio = {"|", 16'h0000};
         8'h2B: trio = {"}]", 8'h00};
         8'h2C: trio = {"zZ", 8'h00};
         8'h2D: trio = {"xX", 8'h00};
         8'h2E: trio = {"cC", 8'h00};
         8'h2F: trio = {"vV", 8'h00};
         8'h30: trio = {"bB", 8'h00};
         8'h31: trio = {"nN", 8'h00};
         8'h32: trio = {"mM", 8'h00};
         8'h33: trio = {",;", 8'h00};
         8'h34: trio = {".:", 8'h00};
         8'h35: trio = {"-_", 8'h00};
         8'h39: trio = "   ";
         8'h55: trio = "<>|";
         default: trio = 24'h000000;
      endcase
      case (col)
         COL_SHIFT: return trio[15:8];
         COL_ALT:   return trio[7:0];
         default:   return trio[23:16];
      endcase
   endfunction

   function automatic out_word_type word_of(input logic dest, input logic [7:0] ch);
      out_word_type w;
      w.destination = dest;
      w.char_code   = ch;
      w.last_of_run = 1'b0;
      return w;
   endfunction

   // Store one character in the pending line, erase one on a backspace; terminators flush it
   task automatic file_char(input logic [7:0] ch);
      if (ch != CH_NL && ch != CH_BS && ch != CH_EOF) begin
         // keep one slot free for a terminator, drop silently otherwise
         if (line_len < LINE_CAPACITY - 1) begin
            run_q.push_back(word_of(DEST_ECHO, ch));
            pending_line[line_len] = ch;
            line_len++;
         end
      end else if (ch == CH_BS) begin
         if (line_len != 0) begin
            line_len--;
            run_q.push_back(word_of(DEST_ECHO, ch));
         end
      end else begin
         if (line_len < LINE_CAPACITY) begin
            pending_line[line_len] = ch;
            line_len++;
         end
         if (ch != CH_EOF) run_q.push_back(word_of(DEST_ECHO, ch));
         for (int i = 0; i < line_len; i++) run_q.push_back(word_of(DEST_LINE, pending_line[i]));
         line_len = 0;
      end
   endtask

   task automatic track_scan_code(input logic [7:0] code);
      out_word_type tail;
      run_q.delete();
      if (code < SC_NUM_MAKE) begin
         if (code == SC_LSHIFT || code == SC_RSHIFT) begin
            column = COL_SHIFT;
         end else if (code == SC_ALT) begin
            column = COL_ALT;
         end else if (code == SC_CAPS) begin
            column = (column == COL_BASE) ? COL_SHIFT : COL_BASE;
         end else if (code == SC_CTRL) begin
            ctrl_down = 1'b1;
         end else if (ctrl_down) begin
            if (code == SC_KEY_D) file_char(CH_EOF);
         end else begin
            file_char(latin_key_char(code, column));
         end
      end else if (code == SC_LSHIFT_BRK || code == SC_RSHIFT_BRK || code == SC_ALT_BRK) begin
         column = COL_BASE;
      end else if (code == SC_CTRL_BRK) begin
         ctrl_down = 1'b0;
      end
      if (run_q.size() > 0) begin
         tail = run_q.pop_back();
         tail.last_of_run = 1'b1;
         run_q.push_back(tail);
      end
      foreach (run_q[i]) expected_q.push_back(run_q[i]);
   endtask

   always @(posedge clock) begin
      out_word_type want;
      if (reset) begin
         column    = COL_BASE;
         ctrl_down = 1'b0;
         line_len  = 0;
         expected_q.delete();
         words_outstanding <= 0;
      end else begin
         // compare first: a word leaving now cannot stem from a scan code entering now
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (expected_q.size() == 0) begin
               $error("unexpected word: destination %0d char_code 0x%02h last_of_run %0d",
                      rsp_ch.destination, rsp_ch.char_code, rsp_ch.last_of_run);
               fail_count++;
            end else begin
               want = expected_q.pop_front();
               if (rsp_ch.destination !== want.destination) begin
                  $error("destination: expected %0d, actual %0d",
                         want.destination, rsp_ch.destination);
                  fail_count++;
               end
               if (rsp_ch.char_code !== want.char_code) begin
                  $error("char_code: expected 0x%02h, actual 0x%02h",
                         want.char_code, rsp_ch.char_code);
                  fail_count++;
               end
               if (rsp_ch.last_of_run !== want.last_of_run) begin
                  $error("last_of_run: expected %0d, actual %0d",
                         want.last_of_run, rsp_ch.last_of_run);
                  fail_count++;
               end
            end
         end
         if (req_ch.valid && req_ch.ready) track_scan_code(req_ch.scan_code);
         words_outstanding <= expected_q.size();
      end
   end

endmodule

// ===== bench/tb_scan_code_to_ascii_line_editor_top.sv =====
`timescale 1ns / 1ps
// Top of the line editor bench: clock, reset, scan code stimulus and verdict.
// Depends on scle_pkg, scle_if, the editor RTL and scle_line_checker.
module tb_scan_code_to_ascii_line_editor_top;
   import scle_pkg::*;

   localparam int LINE_CAP = 32;

   // Keys used by name in the stimulus
   localparam logic [7:0] KEY_UNMAPPED = 8'h00;
   localparam logic [7:0] KEY_Q        = 8'h10;
   localparam logic [7:0] KEY_2        = 8'h03;
   localparam logic [7:0] KEY_A        = 8'h1E;
   localparam logic [7:0] KEY_BS       = 8'h0E;
   localparam logic [7:0] KEY_ENTER    = 8'h1C;
   localparam logic [7:0] KEY_SPACE    = 8'h39;
   localparam logic [7:0] KEY_LESS     = 8'h55;

   localparam logic [7:0] MODIFIER_MAKES [4] = '{SC_LSHIFT, SC_RSHIFT, SC_ALT, SC_CAPS};
   localparam logic [7:0] MODIFIER_BREAKS [3] = '{SC_LSHIFT_BRK, SC_RSHIFT_BRK, SC_ALT_BRK};

   // Opening sequence: one pass over every modifier path, echo, erase, flush, EOF
   // and the ignored codes at the edges of the byte range.
   localparam logic [7:0] OPENING [26] = '{
      KEY_UNMAPPED,                  // table gives zero: still echoed and stored
      KEY_A,
      SC_LSHIFT, KEY_Q, SC_LSHIFT_BRK,
      SC_RSHIFT, KEY_LESS, SC_RSHIFT_BRK,
      SC_ALT, KEY_2,
      SC_CAPS,                       // from the Alt column straight back to base
      SC_CAPS,                       // base to shifted
      KEY_BS,                        // erase with a non-empty line
      SC_ALT_BRK,
      SC_NUM_MAKE, 8'hFF, 8'h7F,     // ignored, no word
      KEY_ENTER,                     // echo, then flush with the newline
      KEY_BS,                        // erase on an empty line: nothing
      SC_CTRL,
      SC_LSHIFT,                     // modifiers still act while Ctrl is down
      KEY_A,                         // ignored under Ctrl
      SC_KEY_D,                      // EOF alone on an empty line
      SC_CTRL_BRK, SC_LSHIFT_BRK,
      8'h80
   };

   localparam int RANDOM_CODES = 424;

   logic clock;
   logic reset;
   int   fail_count;
   int   words_outstanding;
   int   codes_sent;
   int   burst_left;
   logic req_active;

   scle_req_if req_ch();
   scle_rsp_if rsp_ch();

   scan_code_to_ascii_line_editor_top #(
      .LINE_CAPACITY(LINE_CAP)
   ) uut (
      .clock (clock),
      .reset (reset),
      .req_ch(req_ch),
      .rsp_ch(rsp_ch)
   );

   scle_line_checker #(
      .LINE_CAPACITY(LINE_CAP)
   ) line_checker (
      .clock            (clock),
      .reset            (reset),
      .req_ch           (req_ch),
      .rsp_ch           (rsp_ch),
      .fail_count       (fail_count),
      .words_outstanding(words_outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Offer one scan code word and hold it until taken. Bursts of random length
   // keep valid high back to back; a burst ends in a random gap, sometimes none.
   task automatic send_code(input logic [7:0] code);
      int gap;
      req_ch.valid     <= 1'b1;
      req_ch.scan_code <= code;
      req_active = 1'b1;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      codes_sent++;
      burst_left--;
      if (burst_left <= 0) begin
         burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 8);
         gap = $urandom_range(0, 5);
         if (gap > 0) begin
            req_ch.valid <= 1'b0;
            req_active = 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   // Drop valid and hold off until every predicted word has come out. The
   // outstanding count is registered in the checker, so let it update first.
   task automatic wait_for_drain();
      if (req_active) begin
         req_ch.valid <= 1'b0;
         req_active = 1'b0;
      end
      @(posedge clock);
      while (words_outstanding != 0) @(posedge clock);
   endtask

   // Receiver: alternate ready runs and stalls of random length; now and then
   // a long ready run gives stretches with no backpressure at all.
   initial begin
      int   phase_left;
      logic level;
      level      = 1'b0;
      phase_left = 0;
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (phase_left == 0) begin
            level = !level;
            if (level) begin
               phase_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
                                                        : $urandom_range(1, 10);
            end else begin
               phase_left = $urandom_range(1, 6);
            end
            rsp_ch.ready <= level;
         end
         phase_left--;
      end
   end

   // Main sequence
   initial begin
      int         line_len;
      int         pick;
      int         next_pause;
      logic [7:0] code;
      req_ch.valid     <= 1'b0;
      req_ch.scan_code <= 8'h00;
      reset            <= 1'b1;
      req_active = 1'b0;
      codes_sent = 0;
      burst_left = 1;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (OPENING[i]) send_code(OPENING[i]);
      wait_for_drain();

      // Random part: mostly typed lines with random content and a terminator,
      // the rest raw noise bytes and lines left unterminated.
      next_pause = codes_sent + 150;
      while (codes_sent < $size(OPENING) + RANDOM_CODES) begin
         if ($urandom_range(0, 9) < 7) begin
            // release Ctrl half the time so a stray Ctrl from noise does not stick
            if ($urandom_range(0, 1) == 1) send_code(SC_CTRL_BRK);
            // a few long lines run into the full store
            line_len = ($urandom_range(0, 6) == 0) ? $urandom_range(28, 40)
                                                   : $urandom_range(0, 12);
            repeat (line_len) begin
               pick = $urandom_range(0, 19);
               if (pick < 12) begin
                  code = 8'($urandom_range(8'h02, 8'h35));
               end else if (pick == 12) begin
                  code = KEY_SPACE;
               end else if (pick == 13) begin
                  code = KEY_LESS;
               end else if (pick < 16) begin
                  code = KEY_BS;
               end else if (pick == 16) begin
                  code = MODIFIER_MAKES[$urandom_range(0, 3)];
               end else if (pick == 17) begin
                  code = MODIFIER_BREAKS[$urandom_range(0, 2)];
               end else begin
                  code = 8'($urandom_range(0, 8'h55));
               end
               // keep Enter and Ctrl for the terminator
               if (code == KEY_ENTER || code == SC_CTRL) code = KEY_SPACE;
               send_code(code);
            end
            pick = $urandom_range(0, 9);
            if (pick < 5) begin
               send_code(KEY_ENTER);
            end else if (pick < 8) begin
               send_code(SC_CTRL);
               if ($urandom_range(0, 2) == 0) send_code(8'($urandom_range(0, 8'h55)));
               send_code(SC_KEY_D);
               send_code(SC_CTRL_BRK);
            end
         end else begin
            repeat ($urandom_range(1, 4)) send_code(8'($urandom_range(0, 255)));
         end
         if (codes_sent >= next_pause) begin
            wait_for_drain();
            next_pause = codes_sent + 150;
         end
      end

      // Let the last flush finish, then allow for any stray word
      wait_for_drain();
      repeat (40) @(posedge clock);
      if (fail_count == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

   // Guard against a hung handshake
   initial begin
      #10_000_000;
      $display("FAILED: results differ");
      $finish;
   end

endmodule

// ===== files.f =====
rtl/scle_pkg.sv
rtl/scle_if.sv
rtl/scle_ram.sv
rtl/scle_front.sv
rtl/scle_queue.sv
rtl/scle_back.sv
rtl/scan_code_to_ascii_line_editor_top.sv
bench/scle_line_checker.sv
bench/tb_scan_code_to_ascii_line_editor_top.sv
